FILE: src/prq_pkg.sv
// Package for the priority ready queue: request codes, controller states, default sizes.
`timescale 1ns / 1ps
package prq_pkg;

	localparam int ID_W              = 8;
	localparam int REQ_W             = 2;
	localparam int DEF_QUEUE_DEPTH   = 32;
	localparam int DEF_PRIORITY_BITS = 6;

	typedef enum logic [REQ_W-1:0] {
		REQ_INSERT   = 2'd0,
		REQ_DISPATCH = 2'd1,
		REQ_YIELD    = 2'd2,
		REQ_CHECK    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PLACE,
		ST_RD,
		ST_FRONT,
		ST_DONE
	} state_t;

endpackage

FILE: src/prq_mem.sv
// Single-port-write, single-port-read synchronous RAM holding the queue entries.
`timescale 1ns / 1ps
module prq_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 14
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read-before-write on the same address; the controller never relies on it
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/priority_ready_queue_unit.sv
// Top level of the priority ready queue: request controller around the entry RAM.
`timescale 1ns / 1ps
// The queue holds up to QUEUE_DEPTH {thread id, priority} words, sorted by
// descending priority and first-in first-out among equal priorities. A request
// is taken when start is high and busy is low; exactly one result word follows,
// shown for a single cycle with done high, and the receiver cannot stall it.
// Entries live in one synchronous RAM with one read and one write per cycle and
// a registered read port, kept as a ring with a head pointer so a pop never
// moves data. A dispatch or a preemption check that reads the front goes
// through ST_RD, which reads the front, ST_FRONT, which uses it, and ST_DONE.
// An insert walks back from the tail, moving one lower-priority entry up per
// cycle while reading the next one, until it meets an entry of equal or higher
// priority or reaches the front. A yield is an insert followed by a read of the
// front, or the read alone while idle runs. A full queue drops the insert, flags
// overflow and costs no walk. Requests that need no RAM read (an insert into an
// empty or a full queue, a dispatch on an empty queue, a check on an empty
// queue or while idle runs) go from ST_IDLE straight to ST_DONE. No clearing
// pass runs after reset: only entries below the fill count are ever read.
module priority_ready_queue_unit
	import prq_pkg::*;
#(
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
	parameter int PRIORITY_BITS = DEF_PRIORITY_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [REQ_W-1:0]                 req_type,
	input  logic [ID_W-1:0]                  thread_id,
	input  logic [PRIORITY_BITS-1:0]         priority_req,
	input  logic                             current_is_idle,
	output logic                             done,
	output logic [ID_W-1:0]                  next_id,
	output logic [PRIORITY_BITS-1:0]         next_priority,
	output logic                             idle_selected,
	output logic                             should_yield,
	output logic                             overflow,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = ID_W + PRIORITY_BITS;
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

	// Map a position in the queue (0 = front) onto a RAM address of the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
	                                       input logic [AW-1:0] pos);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, pos};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q, count_d;
	logic [AW-1:0]          head_q, head_d;
	logic [AW-1:0]          pos_q, pos_d;
	req_t                   req_q, req_d;
	logic [ID_W-1:0]        tid_q, tid_d;
	logic [PRIORITY_BITS-1:0] prio_q, prio_d;
	logic [ID_W-1:0]        nid_q, nid_d;
	logic [PRIORITY_BITS-1:0] nprio_q, nprio_d;
	logic                   idle_sel_q, idle_sel_d;
	logic                   yield_q, yield_d;
	logic                   ovf_q, ovf_d;

	logic                   accept;
	logic                   full;
	logic                   mem_we, mem_re;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [EW-1:0]          mem_wdata, mem_rdata;
	logic [PRIORITY_BITS-1:0] rd_prio;
	logic [ID_W-1:0]        rd_id;
	req_t                   req_in;

	prq_mem #(
		.DEPTH(QUEUE_DEPTH),
		.WIDTH(EW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign full    = (count_q == FULL_C);
	assign rd_prio = mem_rdata[PRIORITY_BITS-1:0];
	assign rd_id   = mem_rdata[EW-1:PRIORITY_BITS];
	assign req_in  = req_t'(req_type);

	// Result word: registers are loaded during the request, shown in ST_DONE.
	assign done          = (state_q == ST_DONE);
	assign next_id       = nid_q;
	assign next_priority = nprio_q;
	assign idle_selected = idle_sel_q;
	assign should_yield  = yield_q;
	assign overflow      = ovf_q;
	assign queue_count   = count_q;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		head_d     = head_q;
		pos_d      = pos_q;
		req_d      = req_q;
		tid_d      = tid_q;
		prio_d     = prio_q;
		nid_d      = nid_q;
		nprio_d    = nprio_q;
		idle_sel_d = idle_sel_q;
		yield_d    = yield_q;
		ovf_d      = ovf_q;
		mem_we     = 1'b0;
		mem_waddr  = phys(head_q, pos_q);
		mem_wdata  = {tid_q, prio_q};
		mem_re     = 1'b0;
		mem_raddr  = head_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_d      = req_in;
					tid_d      = thread_id;
					prio_d     = priority_req;
					nid_d      = '0;
					nprio_d    = '0;
					idle_sel_d = 1'b0;
					yield_d    = 1'b0;
					ovf_d      = 1'b0;
					unique case (req_in) inside
						REQ_INSERT, REQ_YIELD: begin
							if (req_in == REQ_YIELD && current_is_idle) begin
								// idle thread yields: dispatch only
								if (count_q == '0) begin
									idle_sel_d = 1'b1;
									state_d    = ST_DONE;
								end else begin
									state_d = ST_RD;
								end
							end else if (full) begin
								// drop the insert; a yield still dispatches
								ovf_d   = 1'b1;
								state_d = (req_in == REQ_YIELD) ? ST_RD : ST_DONE;
							end else if (count_q == '0) begin
								// empty queue: place at the front right away
								mem_we    = 1'b1;
								mem_waddr = head_q;
								mem_wdata = {thread_id, priority_req};
								count_d   = count_q + 1'b1;
								state_d   = (req_in == REQ_YIELD) ? ST_RD : ST_DONE;
							end else begin
								// start the walk at the tail
								pos_d     = count_q[AW-1:0];
								mem_re    = 1'b1;
								mem_raddr = phys(head_q, count_q[AW-1:0] - 1'b1);
								state_d   = ST_INS;
							end
						end
						REQ_DISPATCH: begin
							if (count_q == '0) begin
								idle_sel_d = 1'b1;
								state_d    = ST_DONE;
							end else begin
								state_d = ST_RD;
							end
						end
						REQ_CHECK: begin
							state_d = (current_is_idle || count_q == '0) ? ST_DONE : ST_RD;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_INS: begin
				if (rd_prio < prio_q) begin
					// move the lower-priority entry one place back
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					pos_d     = pos_q - 1'b1;
					if (pos_q == AW'(1)) begin
						state_d = ST_PLACE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = phys(head_q, pos_q - AW'(2));
					end
				end else begin
					// slot found behind an entry of equal or higher priority
					mem_we  = 1'b1;
					count_d = count_q + 1'b1;
					state_d = (req_q == REQ_YIELD) ? ST_RD : ST_DONE;
				end
			end
			ST_PLACE: begin
				mem_we  = 1'b1;
				count_d = count_q + 1'b1;
				state_d = (req_q == REQ_YIELD) ? ST_RD : ST_DONE;
			end
			ST_RD: begin
				mem_re    = 1'b1;
				mem_raddr = head_q;
				state_d   = ST_FRONT;
			end
			ST_FRONT: begin
				if (req_q == REQ_CHECK) begin
					yield_d = (rd_prio > prio_q);
				end else begin
					// pop the front entry
					nid_d   = rd_id;
					nprio_d = rd_prio;
					head_d  = (head_q == LAST_A) ? '0 : head_q + 1'b1;
					count_d = count_q - 1'b1;
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			head_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			head_q  <= head_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q      <= pos_d;
		req_q      <= req_d;
		tid_q      <= tid_d;
		prio_q     <= prio_d;
		nid_q      <= nid_d;
		nprio_q    <= nprio_d;
		idle_sel_q <= idle_sel_d;
		yield_q    <= yield_d;
		ovf_q      <= ovf_d;
	end

`ifndef SYNTHESIS
	// The fill count never passes the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_C)
		else $error("queue count above capacity");

	// A dropped insert only happens on a full queue, and a yield then leaves it one short.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (queue_count == FULL_C || queue_count == FULL_C - 1'b1))
		else $error("overflow reported with room in the queue");

	// Idle is selected only when the queue is and stays empty.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(done && idle_selected) |-> (queue_count == '0 && next_id == '0))
		else $error("idle selected with a non-empty queue");

	// The walk never steps past the front.
	a_walk_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (pos_q != '0))
		else $error("insert walk reached position zero");

	// An accepted request keeps the unit busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("request accepted without going busy");
`endif

endmodule

FILE: sim/tb.sv
// Testbench for the priority ready queue unit: scheduler requests checked against a sorted-list model.
`timescale 1ns / 1ps
module tb;
	import prq_pkg::*;

	localparam int QD           = DEF_QUEUE_DEPTH;
	localparam int PB           = DEF_PRIORITY_BITS;
	localparam int CW           = $clog2(QD + 1);
	localparam int RANDOM_WORDS = 630;
	// A yield walks the whole queue once at worst and then reads the front; add the
	// longest sender gap on top.
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 2 * QD + 20;

	// One request word as the driver presents it, with the idle cycles to insert before it.
	typedef struct {
		req_t            req;
		logic [ID_W-1:0] tid;
		logic [PB-1:0]   prio;
		logic            cur_idle;
		int              gap;
	} request_t;

	typedef struct {
		logic [ID_W-1:0] tid;
		logic [PB-1:0]   prio;
	} thread_t;

	typedef struct {
		logic [ID_W-1:0] tid;
		logic [PB-1:0]   prio;
		logic            idle_sel;
		logic            yld;
		logic            ovf;
		logic [CW-1:0]   count;
	} result_t;

	// Stimulus phases: fill the queue past full, drain it past empty, or mix freely.
	typedef enum {
		PH_FILL,
		PH_DRAIN,
		PH_MIX
	} phase_t;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  start           = 1'b0;
	logic [REQ_W-1:0]      req_type        = REQ_INSERT;
	logic [ID_W-1:0]       thread_id       = '0;
	logic [PB-1:0]         priority_req    = '0;
	logic                  current_is_idle = 1'b0;
	logic                  busy;
	logic                  done;
	logic [ID_W-1:0]       next_id;
	logic [PB-1:0]         next_priority;
	logic                  idle_selected;
	logic                  should_yield;
	logic                  overflow;
	logic [CW-1:0]         queue_count;

	request_t pending_words[$];   // words not yet presented to the block
	request_t cur_word;           // word currently on the request ports
	thread_t  sched_list[$];      // model of the ready queue, front at index 0
	result_t  due_results[$];     // results owed by the block, oldest first
	int       gap_left    = 0;
	int       stall_count = 0;
	int       mismatches  = 0;
	int       plan_count  = 0;    // queue fill that the generated words will leave
	int       words_made  = 0;
	bit       burst       = 1'b0;

	priority_ready_queue_unit #(
		.QUEUE_DEPTH   (QD),
		.PRIORITY_BITS (PB)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.req_type        (req_type),
		.thread_id       (thread_id),
		.priority_req    (priority_req),
		.current_is_idle (current_is_idle),
		.done            (done),
		.next_id         (next_id),
		.next_priority   (next_priority),
		.idle_selected   (idle_selected),
		.should_yield    (should_yield),
		.overflow        (overflow),
		.queue_count     (queue_count)
	);

	always #10 clk = ~clk;

	// Place a thread after every entry of equal or higher priority; report a drop when full.
	function automatic bit enqueue_thread(input logic [ID_W-1:0] tid, input logic [PB-1:0] prio);
		thread_t t;
		int      pos;
		if (sched_list.size() >= QD)
			return 1'b0;
		pos = 0;
		while (pos < sched_list.size() && sched_list[pos].prio >= prio)
			pos++;
		t.tid  = tid;
		t.prio = prio;
		sched_list.insert(pos, t);
		return 1'b1;
	endfunction

	// Pop the front thread into the result, or select idle on an empty queue.
	function automatic void take_front(inout result_t r);
		if (sched_list.size() == 0) begin
			r.idle_sel = 1'b1;
		end else begin
			r.tid  = sched_list[0].tid;
			r.prio = sched_list[0].prio;
			sched_list.delete(0);
		end
	endfunction

	// Apply one accepted request to the model and queue up the result it owes.
	function automatic void run_request(input request_t rq);
		result_t r;
		r = '{default: '0};
		case (rq.req)
			REQ_INSERT: begin
				r.ovf = !enqueue_thread(rq.tid, rq.prio);
			end
			REQ_YIELD: begin
				// Re-insert the running thread first unless idle is running, then dispatch.
				if (!rq.cur_idle)
					r.ovf = !enqueue_thread(rq.tid, rq.prio);
				take_front(r);
			end
			REQ_DISPATCH: begin
				take_front(r);
			end
			default: begin
				r.yld = !rq.cur_idle && sched_list.size() > 0 && sched_list[0].prio > rq.prio;
			end
		endcase
		r.count = CW'(sched_list.size());
		due_results.push_back(r);
	endfunction

	// Priorities cluster at the ends and the middle so equal priorities are common.
	function automatic logic [PB-1:0] rand_prio();
		case ($urandom_range(0, 3))
			0:       return PB'($urandom_range(0, (1 << PB) - 1));
			1:       return PB'($urandom_range(0, 3));
			2:       return PB'($urandom_range((1 << PB) - 4, (1 << PB) - 1));
			default: return PB'($urandom_range(30, 33));
		endcase
	endfunction

	// Draw any thread id.
	function automatic logic [ID_W-1:0] rand_tid();
		return ID_W'($urandom_range(0, (1 << ID_W) - 1));
	endfunction

	// Draw a single random bit.
	function automatic logic rand_bit();
		return 1'($urandom_range(0, 1));
	endfunction

	// Queue one word for the driver and track the fill it leaves behind.
	task automatic add_word(input req_t r, input logic [ID_W-1:0] tid,
			input logic [PB-1:0] prio, input logic ci);
		request_t w;
		// Switch between bursts with no gaps and gapped stretches every 40 words.
		if (words_made % 40 == 0)
			burst = ($urandom_range(0, 3) == 0);
		w.req      = r;
		w.tid      = tid;
		w.prio     = prio;
		w.cur_idle = ci;
		w.gap      = burst ? 0 : $urandom_range(0, 7);
		pending_words.push_back(w);
		words_made++;
		case (r)
			REQ_INSERT: begin
				if (plan_count < QD)
					plan_count++;
			end
			REQ_DISPATCH: begin
				if (plan_count > 0)
					plan_count--;
			end
			REQ_YIELD: begin
				if (!ci && plan_count < QD)
					plan_count++;
				if (plan_count > 0)
					plan_count--;
			end
			default: ;
		endcase
	endtask

	// Driver: hold each word until the block takes it, then count down the gap and load the next.
	always @(posedge clk or negedge arst_n) begin
		bit fire;
		if (!arst_n) begin
			start           <= 1'b0;
			req_type        <= REQ_INSERT;
			thread_id       <= '0;
			priority_req    <= '0;
			current_is_idle <= 1'b0;
			gap_left         = 0;
		end else begin
			fire = start && !busy;
			if (fire)
				run_request(cur_word);
			if (fire || !start) begin
				if (pending_words.size() > 0 && gap_left == 0) begin
					cur_word         = pending_words.pop_front();
					req_type        <= cur_word.req;
					thread_id       <= cur_word.tid;
					priority_req    <= cur_word.prio;
					current_is_idle <= cur_word.cur_idle;
					start           <= 1'b1;
					gap_left         = (pending_words.size() > 0) ? pending_words[0].gap : 0;
				end else begin
					start <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	// Monitor: check every done word against the oldest owed result and watch for a stall.
	always @(posedge clk or negedge arst_n) begin
		result_t r;
		if (!arst_n) begin
			stall_count <= 0;
		end else begin
			if ((start && !busy) || done)
				stall_count <= 0;
			else
				stall_count <= stall_count + 1;
			if (done) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result word: id %0d prio %0d count %0d",
							next_id, next_priority, queue_count);
				end else begin
					r = due_results.pop_front();
					if (r.tid !== next_id || r.prio !== next_priority ||
							r.idle_sel !== idle_selected || r.yld !== should_yield ||
							r.ovf !== overflow || r.count !== queue_count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"ERROR: result mismatch: expected id %0d prio %0d idle %0b ",
								"yield %0b ovf %0b count %0d, got id %0d prio %0d idle %0b ",
								"yield %0b ovf %0b count %0d"},
								r.tid, r.prio, r.idle_sel, r.yld, r.ovf, r.count,
								next_id, next_priority, idle_selected, should_yield,
								overflow, queue_count);
					end
				end
			end
		end
	end

	initial begin
		phase_t phase;
		int     hits;
		int     mix_left;
		int     pick;
		int     n;
		bit     timed_out;

		// Directed words: empty-queue cases first, then the extremes and FIFO order.
		add_word(REQ_DISPATCH, 8'd0, '0, 1'b0);
		add_word(REQ_YIELD, 8'd9, 6'd20, 1'b1);
		add_word(REQ_CHECK, 8'd0, '0, 1'b0);
		add_word(REQ_YIELD, 8'd200, 6'd5, 1'b0);
		add_word(REQ_INSERT, 8'd255, 6'd63, 1'b1);
		add_word(REQ_INSERT, 8'd0, 6'd0, 1'b0);
		add_word(REQ_INSERT, 8'h5a, 6'd63, 1'b0);
		add_word(REQ_INSERT, 8'ha5, 6'd0, 1'b1);
		add_word(REQ_INSERT, 8'h33, 6'd31, 1'b0);
		add_word(REQ_CHECK, 8'd1, 6'd0, 1'b1);
		add_word(REQ_CHECK, 8'd1, 6'd62, 1'b0);
		add_word(REQ_CHECK, 8'd1, 6'd63, 1'b0);
		add_word(REQ_YIELD, 8'h77, 6'd63, 1'b0);
		add_word(REQ_YIELD, 8'h12, 6'd10, 1'b1);
		add_word(REQ_DISPATCH, 8'hff, 6'd63, 1'b0);
		add_word(REQ_DISPATCH, 8'd0, 6'd0, 1'b1);
		add_word(REQ_DISPATCH, 8'd0, 6'd0, 1'b0);
		add_word(REQ_DISPATCH, 8'd0, 6'd0, 1'b0);
		add_word(REQ_DISPATCH, 8'd0, 6'd0, 1'b0);
		add_word(REQ_INSERT, 8'd1, 6'd63, 1'b0);
		add_word(REQ_CHECK, 8'd2, 6'd63, 1'b0);
		add_word(REQ_CHECK, 8'd2, 6'd0, 1'b0);

		// Random words: cycle the queue through full and empty, with free mixes between.
		phase    = PH_FILL;
		hits     = 0;
		mix_left = 0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			pick = $urandom_range(0, 9);
			case (phase)
				PH_FILL: begin
					if (plan_count == QD) begin
						// Hit the full queue with inserts, non-idle yields and checks.
						hits++;
						case (pick % 3)
							0:       add_word(REQ_INSERT, rand_tid(), rand_prio(), rand_bit());
							1:       add_word(REQ_YIELD, rand_tid(), rand_prio(), 1'b0);
							default: add_word(REQ_CHECK, rand_tid(), rand_prio(), rand_bit());
						endcase
						if (hits >= 4) begin
							phase = PH_DRAIN;
							hits  = 0;
						end
					end else if (pick < 7) begin
						add_word(REQ_INSERT, rand_tid(), rand_prio(), rand_bit());
					end else if (pick == 7) begin
						add_word(REQ_CHECK, rand_tid(), rand_prio(), rand_bit());
					end else if (pick == 8) begin
						add_word(REQ_YIELD, rand_tid(), rand_prio(), rand_bit());
					end else begin
						add_word(REQ_DISPATCH, rand_tid(), rand_prio(), rand_bit());
					end
				end
				PH_DRAIN: begin
					if (plan_count == 0) begin
						// Poke the empty queue, then move on to a new phase.
						hits++;
						case (pick % 3)
							0:       add_word(REQ_DISPATCH, rand_tid(), rand_prio(), rand_bit());
							1:       add_word(REQ_YIELD, rand_tid(), rand_prio(), rand_bit());
							default: add_word(REQ_CHECK, rand_tid(), rand_prio(), rand_bit());
						endcase
						if (hits >= 3) begin
							hits     = 0;
							phase    = $urandom_range(0, 1) ? PH_MIX : PH_FILL;
							mix_left = $urandom_range(20, 40);
						end
					end else if (pick < 6) begin
						add_word(REQ_DISPATCH, rand_tid(), rand_prio(), rand_bit());
					end else if (pick < 8) begin
						add_word(REQ_YIELD, rand_tid(), rand_prio(), rand_bit());
					end else if (pick == 8) begin
						add_word(REQ_CHECK, rand_tid(), rand_prio(), rand_bit());
					end else begin
						add_word(REQ_INSERT, rand_tid(), rand_prio(), rand_bit());
					end
				end
				default: begin
					add_word(req_t'(REQ_W'($urandom_range(0, 3))), rand_tid(), rand_prio(),
						rand_bit());
					mix_left--;
					if (mix_left <= 0)
						phase = PH_FILL;
				end
			endcase
		end

		// Release reset on a clock edge once the stimulus is in place.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every word is taken and every result has come back, or the block stalls.
		timed_out = 1'b0;
		while (!timed_out && (pending_words.size() != 0 || start || due_results.size() != 0)) begin
			@(posedge clk);
			timed_out = (stall_count >= STALL_LIMIT);
		end

		if (timed_out) begin
			$display("ERROR: no progress for %0d cycles", STALL_LIMIT);
			$display("FAILURE");
		end else begin
			// Leave room for any stray result word to show up.
			repeat (DRAIN_CYCLES) @(posedge clk);
			if (mismatches == 0 && due_results.size() == 0) begin
				$display("SUCCESS");
			end else begin
				$display("ERROR: %0d mismatches, %0d results outstanding", mismatches,
					due_results.size());
				$display("FAILURE");
			end
		end
		$finish;
	end

endmodule
